[rtl/postfix_packet_filter_evaluator_assert.svh]
// Assertion macros shared by the checker files of the filter evaluator.
`ifndef POSTFIX_PACKET_FILTER_EVALUATOR_ASSERT_SVH
`define POSTFIX_PACKET_FILTER_EVALUATOR_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define PFE_ASSERT_ALWAYS(label, ck, rn, expr) \
    label: assert property (@(posedge ck) disable iff (!rn) (expr)) \
        else $error("filter evaluator check failed");

// A condition that must hold in the cycle after a trigger.
`define PFE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("filter evaluator check failed");

`endif

[rtl/pfe_pkg.sv]
`default_nettype none

package pfe_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Item field widths.
    localparam int CMD_W   = 4;
    localparam int VAL_W   = 64;
    localparam int SEL_W   = 4;
    localparam int LEVEL_W = 5;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 72;

    // Frame and protocol codes.
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] TYPE_ARP   = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // Token commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 4'd0,
        CMD_LOAD  = 4'd1,
        CMD_LIT   = 4'd2,
        CMD_FIELD = 4'd3,
        CMD_EQ    = 4'd4,
        CMD_AND   = 4'd5,
        CMD_OR    = 4'd6,
        CMD_NOT   = 4'd7,
        CMD_ADD   = 4'd8,
        CMD_SUB   = 4'd9,
        CMD_MUL   = 4'd10,
        CMD_DIV   = 4'd11,
        CMD_MOD   = 4'd12
    } cmd_t;

    // Header register selectors.
    typedef enum logic [SEL_W-1:0] {
        HDR_MAC_DST  = 4'd0,
        HDR_MAC_SRC  = 4'd1,
        HDR_TYPE     = 4'd2,
        HDR_PROTO    = 4'd3,
        HDR_IP_SRC   = 4'd4,
        HDR_IP_DST   = 4'd5,
        HDR_PORT_SRC = 4'd6,
        HDR_PORT_DST = 4'd7,
        HDR_ICMP     = 4'd8
    } hdr_sel_t;

    // Derived field selectors.
    typedef enum logic [SEL_W-1:0] {
        FLD_IP        = 4'd0,
        FLD_UDP       = 4'd1,
        FLD_TCP       = 4'd2,
        FLD_ICMP      = 4'd3,
        FLD_ARP       = 4'd4,
        FLD_ETHER_TO  = 4'd5,
        FLD_ETHER_FR  = 4'd6,
        FLD_ETHERTYPE = 4'd7,
        FLD_IP_TO     = 4'd8,
        FLD_IP_FROM   = 4'd9,
        FLD_IP_PROTO  = 4'd10,
        FLD_UDP_TO    = 4'd11,
        FLD_UDP_FROM  = 4'd12,
        FLD_TCP_TO    = 4'd13,
        FLD_TCP_FROM  = 4'd14,
        FLD_ICMP_TYPE = 4'd15
    } fld_sel_t;

    // Class of a token, set by the front end.
    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_CLEAR,
        KIND_LOAD,
        KIND_PUSH,
        KIND_UNARY,
        KIND_BINARY,
        KIND_MULDIV
    } kind_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULDIV,
        ST_COMMIT
    } state_t;

    // One classified token in the queue.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        kind_t            kind;
        logic [VAL_W-1:0] literal;
        logic [SEL_W-1:0] field_select;
    } token_t;

    // Request to the multiply and divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
        logic want_rem;
    } md_req_t;

endpackage

`default_nettype wire

[rtl/pfe_front.sv]
`default_nettype none

module pfe_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [pfe_pkg::IN_W-1:0] s_tdata,
    output logic                          q_valid,
    input  wire logic                     q_pop,
    output pfe_pkg::token_t               q_token
);

    pfe_pkg::token_t fifo_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            push;
    pfe_pkg::token_t token_in;

    // Unpack the item and classify its command.
    always_comb
    begin
        token_in.cmd          = s_tdata[3:0];
        token_in.literal      = s_tdata[67:4];
        token_in.field_select = s_tdata[71:68];
        unique case (s_tdata[3:0])
            pfe_pkg::CMD_CLEAR: token_in.kind = pfe_pkg::KIND_CLEAR;
            pfe_pkg::CMD_LOAD:  token_in.kind = pfe_pkg::KIND_LOAD;
            pfe_pkg::CMD_LIT,
            pfe_pkg::CMD_FIELD: token_in.kind = pfe_pkg::KIND_PUSH;
            pfe_pkg::CMD_NOT:   token_in.kind = pfe_pkg::KIND_UNARY;
            pfe_pkg::CMD_EQ,
            pfe_pkg::CMD_AND,
            pfe_pkg::CMD_OR,
            pfe_pkg::CMD_ADD,
            pfe_pkg::CMD_SUB:   token_in.kind = pfe_pkg::KIND_BINARY;
            pfe_pkg::CMD_MUL,
            pfe_pkg::CMD_DIV,
            pfe_pkg::CMD_MOD:   token_in.kind = pfe_pkg::KIND_MULDIV;
            default:            token_in.kind = pfe_pkg::KIND_NOP;
        endcase
    end

    // Two-entry queue toward the back end.
    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_token  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= token_in;
        end
    end

endmodule

`default_nettype wire

[rtl/pfe_muldiv.sv]
`default_nettype none

module pfe_muldiv (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pfe_pkg::md_req_t          req,
    input  wire logic [pfe_pkg::VAL_W-1:0] a,
    input  wire logic [pfe_pkg::VAL_W-1:0] b,
    output logic                           done,
    output logic [pfe_pkg::VAL_W-1:0]      result
);

    logic                      busy_reg;
    logic                      done_reg;
    logic                      div_reg;
    logic                      rem_sel_reg;
    logic [5:0]                step_reg;
    logic [pfe_pkg::VAL_W-1:0] a_reg;
    logic [pfe_pkg::VAL_W-1:0] b_reg;
    logic [pfe_pkg::VAL_W-1:0] acc_reg, acc_next;
    logic [pfe_pkg::VAL_W-1:0] quo_reg, quo_next;
    logic [31:0]               mul_x;
    logic [31:0]               mul_y;
    logic [63:0]               prod;
    logic [64:0]               shifted;
    logic [64:0]               diff;
    logic                      last;

    // One 32x32 multiplier shared over three partial products.
    always_comb
    begin
        mul_x = a_reg[31:0];
        mul_y = b_reg[31:0];
        if (step_reg == 6'd1)
        begin
            mul_y = b_reg[63:32];
        end
        else if (step_reg == 6'd2)
        begin
            mul_x = a_reg[63:32];
        end
        prod = mul_x * mul_y;
    end

    // Restoring division, one quotient bit a cycle.
    always_comb
    begin
        shifted = {acc_reg, quo_reg[63]};
        diff    = shifted - {1'b0, b_reg};
        if (div_reg)
        begin
            if (!diff[64])
            begin
                acc_next = diff[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                acc_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            last = (step_reg == 6'd63);
        end
        else
        begin
            quo_next = quo_reg;
            if (step_reg == 6'd0)
            begin
                acc_next = prod;
            end
            else
            begin
                acc_next = acc_reg + {prod[31:0], 32'd0};
            end
            last = (step_reg == 6'd2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 6'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 6'd1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg       <= a;
            b_reg       <= b;
            div_reg     <= req.is_div;
            rem_sel_reg <= req.want_rem;
            acc_reg     <= '0;
            quo_reg     <= a;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            quo_reg <= quo_next;
        end
    end

    assign done   = done_reg;
    assign result = (div_reg && !rem_sel_reg) ? quo_reg : acc_reg;

endmodule

`default_nettype wire

[rtl/pfe_back.sv]
`default_nettype none

module pfe_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    output logic                           q_pop,
    input  wire pfe_pkg::token_t           q_token,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [pfe_pkg::OUT_W-1:0]      m_tdata
);

    localparam int CW = pfe_pkg::CNT_W;
    localparam int AW = pfe_pkg::ADDR_W;
    localparam int VW = pfe_pkg::VAL_W;

    pfe_pkg::state_t  st_reg, st_next;
    pfe_pkg::token_t  op_reg;
    pfe_pkg::md_req_t md_req;

    // Stack: top kept in a register, the rest in memory.
    logic [VW-1:0] mem [pfe_pkg::STACK_DEPTH];
    logic [VW-1:0] rd_data_reg;
    logic [VW-1:0] top_reg, top_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_m2;
    logic          mem_we;

    // Header registers.
    logic [47:0] mac_dst_reg;
    logic [47:0] mac_src_reg;
    logic [15:0] type_reg;
    logic [7:0]  proto_reg;
    logic [31:0] ip_src_reg;
    logic [31:0] ip_dst_reg;
    logic [15:0] port_src_reg;
    logic [15:0] port_dst_reg;
    logic [7:0]  icmp_reg;

    // Output register.
    logic          out_valid_reg;
    logic [VW-1:0] out_top_reg;
    logic [pfe_pkg::LEVEL_W-1:0] out_level_reg;
    logic          out_ovf_reg;
    logic          out_zdiv_reg;

    logic          out_free;
    logic          rd_en;
    logic          commit;
    logic          zero_div;
    logic          overflow;
    logic          is_ip, is_arp, is_tcp, is_udp, is_icmp;
    logic [VW-1:0] field_val;
    logic [VW-1:0] opnd_a, opnd_b;
    logic [VW-1:0] alu_res;
    logic [VW-1:0] res;
    logic [VW-1:0] md_result;
    logic          md_done;

    assign out_free = !out_valid_reg || m_tready;
    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);

    // Operands: an empty slot reads as zero.
    assign opnd_b   = (count_reg != '0) ? top_reg : '0;
    assign opnd_a   = (count_reg > CW'(1)) ? rd_data_reg : '0;
    assign zero_div = (op_reg.kind == pfe_pkg::KIND_MULDIV) &&
                      (op_reg.cmd != pfe_pkg::CMD_MUL) && (opnd_b == '0);

    // Packet classification and derived fields.
    always_comb
    begin
        is_ip   = (type_reg == pfe_pkg::TYPE_IPV4);
        is_arp  = (type_reg == pfe_pkg::TYPE_ARP);
        is_tcp  = is_ip && (proto_reg == pfe_pkg::PROTO_TCP);
        is_udp  = is_ip && (proto_reg == pfe_pkg::PROTO_UDP);
        is_icmp = is_ip && (proto_reg == pfe_pkg::PROTO_ICMP);
        unique case (op_reg.field_select)
            pfe_pkg::FLD_IP:        field_val = VW'(is_ip);
            pfe_pkg::FLD_UDP:       field_val = VW'(is_udp);
            pfe_pkg::FLD_TCP:       field_val = VW'(is_tcp);
            pfe_pkg::FLD_ICMP:      field_val = VW'(is_icmp);
            pfe_pkg::FLD_ARP:       field_val = VW'(is_arp);
            pfe_pkg::FLD_ETHER_TO:  field_val = VW'(mac_dst_reg);
            pfe_pkg::FLD_ETHER_FR:  field_val = VW'(mac_src_reg);
            pfe_pkg::FLD_ETHERTYPE: field_val = VW'(type_reg);
            pfe_pkg::FLD_IP_TO:     field_val = is_ip ? VW'(ip_dst_reg) : '0;
            pfe_pkg::FLD_IP_FROM:   field_val = is_ip ? VW'(ip_src_reg) : '0;
            pfe_pkg::FLD_IP_PROTO:  field_val = is_ip ? VW'(proto_reg) : '0;
            pfe_pkg::FLD_UDP_TO:    field_val = is_udp ? VW'(port_dst_reg) : '0;
            pfe_pkg::FLD_UDP_FROM:  field_val = is_udp ? VW'(port_src_reg) : '0;
            pfe_pkg::FLD_TCP_TO:    field_val = is_tcp ? VW'(port_dst_reg) : '0;
            pfe_pkg::FLD_TCP_FROM:  field_val = is_tcp ? VW'(port_src_reg) : '0;
            default:                field_val = is_icmp ? VW'(icmp_reg) : '0;
        endcase
    end

    // Combinational operators other than multiply and divide.
    always_comb
    begin
        unique case (op_reg.cmd)
            pfe_pkg::CMD_LIT:   alu_res = op_reg.literal;
            pfe_pkg::CMD_FIELD: alu_res = field_val;
            pfe_pkg::CMD_EQ:    alu_res = VW'(opnd_a == opnd_b);
            pfe_pkg::CMD_AND:   alu_res = VW'((opnd_a != '0) && (opnd_b != '0));
            pfe_pkg::CMD_OR:    alu_res = VW'((opnd_a != '0) || (opnd_b != '0));
            pfe_pkg::CMD_NOT:   alu_res = VW'(opnd_b == '0);
            pfe_pkg::CMD_ADD:   alu_res = opnd_a + opnd_b;
            pfe_pkg::CMD_SUB:   alu_res = opnd_a - opnd_b;
            default:            alu_res = '0;
        endcase
    end

    assign res = (st_reg == pfe_pkg::ST_COMMIT) ? md_result : alu_res;

    // Sequencer next state.
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            pfe_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    st_next = pfe_pkg::ST_EXEC;
                end
            end
            pfe_pkg::ST_EXEC:
            begin
                if (op_reg.kind == pfe_pkg::KIND_MULDIV && !zero_div)
                begin
                    st_next = pfe_pkg::ST_MULDIV;
                end
                else if (out_free)
                begin
                    st_next = pfe_pkg::ST_IDLE;
                end
            end
            pfe_pkg::ST_MULDIV:
            begin
                if (md_done)
                begin
                    st_next = pfe_pkg::ST_COMMIT;
                end
            end
            pfe_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    st_next = pfe_pkg::ST_IDLE;
                end
            end
            default: st_next = pfe_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        commit         = 1'b0;
        md_req.start    = 1'b0;
        md_req.is_div   = (op_reg.cmd != pfe_pkg::CMD_MUL);
        md_req.want_rem = (op_reg.cmd == pfe_pkg::CMD_MOD);
        unique case (st_reg)
            pfe_pkg::ST_IDLE:
            begin
                q_pop = q_valid;
                rd_en = q_valid;
            end
            pfe_pkg::ST_EXEC:
            begin
                if (op_reg.kind == pfe_pkg::KIND_MULDIV && !zero_div)
                begin
                    md_req.start = 1'b1;
                end
                else
                begin
                    commit = out_free;
                end
            end
            pfe_pkg::ST_COMMIT: commit = out_free;
            default: ;
        endcase
    end

    // Stack update for the token being committed.
    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        overflow   = 1'b0;
        unique case (op_reg.kind)
            pfe_pkg::KIND_CLEAR: count_next = '0;
            pfe_pkg::KIND_PUSH:
            begin
                if (count_reg == CW'(pfe_pkg::STACK_DEPTH))
                begin
                    overflow = 1'b1;
                end
                else
                begin
                    mem_we     = (count_reg != '0);
                    top_next   = res;
                    count_next = count_reg + CW'(1);
                end
            end
            pfe_pkg::KIND_UNARY:
            begin
                top_next   = res;
                count_next = (count_reg == '0) ? CW'(1) : count_reg;
            end
            pfe_pkg::KIND_BINARY,
            pfe_pkg::KIND_MULDIV:
            begin
                top_next   = zero_div ? '0 : res;
                count_next = (count_reg > CW'(1)) ? count_m1 : CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= pfe_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            mac_dst_reg   <= '0;
            mac_src_reg   <= '0;
            type_reg      <= '0;
            proto_reg     <= '0;
            ip_src_reg    <= '0;
            ip_dst_reg    <= '0;
            port_src_reg  <= '0;
            port_dst_reg  <= '0;
            icmp_reg      <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                if (op_reg.kind == pfe_pkg::KIND_LOAD)
                begin
                    unique case (op_reg.field_select)
                        pfe_pkg::HDR_MAC_DST:  mac_dst_reg  <= op_reg.literal[47:0];
                        pfe_pkg::HDR_MAC_SRC:  mac_src_reg  <= op_reg.literal[47:0];
                        pfe_pkg::HDR_TYPE:     type_reg     <= op_reg.literal[15:0];
                        pfe_pkg::HDR_PROTO:    proto_reg    <= op_reg.literal[7:0];
                        pfe_pkg::HDR_IP_SRC:   ip_src_reg   <= op_reg.literal[31:0];
                        pfe_pkg::HDR_IP_DST:   ip_dst_reg   <= op_reg.literal[31:0];
                        pfe_pkg::HDR_PORT_SRC: port_src_reg <= op_reg.literal[15:0];
                        pfe_pkg::HDR_PORT_DST: port_dst_reg <= op_reg.literal[15:0];
                        pfe_pkg::HDR_ICMP:     icmp_reg     <= op_reg.literal[7:0];
                        default: ;
                    endcase
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_token;
        end
        if (commit)
        begin
            top_reg       <= top_next;
            out_top_reg   <= (count_next != '0) ? top_next : '0;
            out_level_reg <= pfe_pkg::LEVEL_W'(count_next);
            out_ovf_reg   <= overflow;
            out_zdiv_reg  <= zero_div;
        end
    end

    // Stack memory below the top entry.
    always_ff @(posedge clk)
    begin
        if (commit && mem_we)
        begin
            mem[count_m1[AW-1:0]] <= top_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[count_m2[AW-1:0]];
        end
    end

    pfe_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .a      (opnd_a),
        .b      (opnd_b),
        .done   (md_done),
        .result (md_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_zdiv_reg, out_ovf_reg, out_level_reg, out_top_reg};

endmodule

`default_nettype wire

[rtl/postfix_packet_filter_evaluator.sv]
// Postfix packet-filter evaluator.
// Input channel s_*: one filter token per item (command, literal, field_select).
// Output channel m_*: one result item per token with the top of the value stack
// (0 when empty), the stack depth, and the overflow and zero-divide flags.
// A two-entry token queue sits between the front end and the execution back end,
// and the result is held in an output register, so a stalled receiver only stops
// the back end while new tokens still fill the queue.
// Tokens are executed one at a time: a token is taken from the queue while the
// stack memory is read, then executed; mul uses three passes of one 32x32
// multiplier and div and mod one quotient bit per cycle, holding the back end
// until that unit is done. Division by zero skips the divider.
// Reset clears the stack depth, the header registers, the token queue and m_tvalid;
// stack entries need no clearing since only written entries are ever read.
// When m_tready is low the result stays on m_tdata unchanged until taken.
`default_nettype none

module postfix_packet_filter_evaluator (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // command[3:0], literal[67:4], field_select[71:68]
    input  wire logic [pfe_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // top_value[63:0], stack_level[68:64], overflow_flag[69],
    // zero_divide_flag[70], zero[71]
    output logic [pfe_pkg::OUT_W-1:0]      m_tdata
);

    logic            q_valid;
    logic            q_pop;
    pfe_pkg::token_t q_token;

    pfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_token  (q_token)
    );

    pfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_token  (q_token),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/pfe_checker.sv]
`default_nettype none
`include "postfix_packet_filter_evaluator_assert.svh"

module pfe_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     s_tready,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [pfe_pkg::OUT_W-1:0] m_tdata
);

    logic [pfe_pkg::VAL_W-1:0]   out_top;
    logic [pfe_pkg::LEVEL_W-1:0] out_level;
    logic                        out_ovf;
    logic                        out_zdiv;

    // Result fields as they appear on the output bus.
    assign out_top   = m_tdata[63:0];
    assign out_level = m_tdata[68:64];
    assign out_ovf   = m_tdata[69];
    assign out_zdiv  = m_tdata[70];

    // Both handshake outputs are driven to known levels out of reset.
    `PFE_ASSERT_ALWAYS(a_known_hs, clk, rst_n, !$isunknown({s_tready, m_tvalid}))

    // A stalled result holds.
    `PFE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The reported depth never exceeds the stack.
    `PFE_ASSERT_ALWAYS(a_level_max, clk, rst_n, !m_tvalid || out_level <= 5'd16)

    // An empty stack reports a zero top.
    `PFE_ASSERT_ALWAYS(a_empty_top, clk, rst_n, !m_tvalid || out_level != 5'd0 || out_top == '0)

    // A zero divide leaves a result on the stack and never overflows.
    `PFE_ASSERT_ALWAYS(a_zdiv_flags, clk, rst_n, !m_tvalid || !out_zdiv || (!out_ovf && out_level != 5'd0 && out_top == '0))

endmodule

bind postfix_packet_filter_evaluator pfe_checker u_pfe_checker (.*);

`default_nettype wire

[test/postfix_packet_filter_evaluator_test.sv]
`timescale 1ns / 1ps

module postfix_packet_filter_evaluator_test;

    // Command and header codes outside the defined sets.
    localparam logic [pfe_pkg::CMD_W-1:0] CMD_RESERVED_LO = 4'd13;
    localparam logic [pfe_pkg::CMD_W-1:0] CMD_RESERVED_HI = 4'd15;
    localparam logic [pfe_pkg::SEL_W-1:0] HDR_UNUSED      = 4'd9;
    localparam int                        ITEM_COUNT      = 1850;
    localparam int                        IDLE_LIMIT      = 5000;

    // Result fields as they leave the block.
    typedef struct {
        logic [pfe_pkg::VAL_W-1:0]   top_value;
        logic [pfe_pkg::LEVEL_W-1:0] stack_level;
        logic                        overflow_flag;
        logic                        zero_divide_flag;
    } filter_result_t;

    // Keeps a shadow of the evaluator and the queue of results it predicts.
    class filter_scoreboard;
        logic [pfe_pkg::VAL_W-1:0] shadow_stack [pfe_pkg::STACK_DEPTH];
        int                        depth;
        logic [47:0]               mac_dst, mac_src;
        logic [15:0]               frame_type, port_src, port_dst;
        logic [7:0]                proto_code, icmp_kind;
        logic [31:0]               ip_src, ip_dst;
        filter_result_t            pending [$];
        int                        errors;

        function new();
            depth = 0;
            mac_dst = '0; mac_src = '0; frame_type = '0; port_src = '0;
            port_dst = '0; proto_code = '0; icmp_kind = '0; ip_src = '0;
            ip_dst = '0; errors = 0;
        endfunction

        function logic [pfe_pkg::VAL_W-1:0] pop_entry();
            if (depth == 0)
                return '0;
            depth--;
            return shadow_stack[depth];
        endfunction

        function bit push_entry(logic [pfe_pkg::VAL_W-1:0] v);
            if (depth >= pfe_pkg::STACK_DEPTH)
                return 1'b1;
            shadow_stack[depth] = v;
            depth++;
            return 1'b0;
        endfunction

        function logic [pfe_pkg::VAL_W-1:0] packet_field(logic [pfe_pkg::SEL_W-1:0] sel);
            bit is_ip, is_tcp, is_udp, is_icmp;
            is_ip   = frame_type == pfe_pkg::TYPE_IPV4;
            is_tcp  = is_ip && proto_code == pfe_pkg::PROTO_TCP;
            is_udp  = is_ip && proto_code == pfe_pkg::PROTO_UDP;
            is_icmp = is_ip && proto_code == pfe_pkg::PROTO_ICMP;
            case (pfe_pkg::fld_sel_t'(sel))
                pfe_pkg::FLD_IP:        return pfe_pkg::VAL_W'(is_ip);
                pfe_pkg::FLD_UDP:       return pfe_pkg::VAL_W'(is_udp);
                pfe_pkg::FLD_TCP:       return pfe_pkg::VAL_W'(is_tcp);
                pfe_pkg::FLD_ICMP:      return pfe_pkg::VAL_W'(is_icmp);
                pfe_pkg::FLD_ARP:
                    return pfe_pkg::VAL_W'(frame_type == pfe_pkg::TYPE_ARP);
                pfe_pkg::FLD_ETHER_TO:  return pfe_pkg::VAL_W'(mac_dst);
                pfe_pkg::FLD_ETHER_FR:  return pfe_pkg::VAL_W'(mac_src);
                pfe_pkg::FLD_ETHERTYPE: return pfe_pkg::VAL_W'(frame_type);
                pfe_pkg::FLD_IP_TO:     return is_ip ? pfe_pkg::VAL_W'(ip_dst) : '0;
                pfe_pkg::FLD_IP_FROM:   return is_ip ? pfe_pkg::VAL_W'(ip_src) : '0;
                pfe_pkg::FLD_IP_PROTO:  return is_ip ? pfe_pkg::VAL_W'(proto_code) : '0;
                pfe_pkg::FLD_UDP_TO:    return is_udp ? pfe_pkg::VAL_W'(port_dst) : '0;
                pfe_pkg::FLD_UDP_FROM:  return is_udp ? pfe_pkg::VAL_W'(port_src) : '0;
                pfe_pkg::FLD_TCP_TO:    return is_tcp ? pfe_pkg::VAL_W'(port_dst) : '0;
                pfe_pkg::FLD_TCP_FROM:  return is_tcp ? pfe_pkg::VAL_W'(port_src) : '0;
                default:                return is_icmp ? pfe_pkg::VAL_W'(icmp_kind) : '0;
            endcase
        endfunction

        // Applies one accepted token and queues the result it should produce.
        function void note_token(logic [pfe_pkg::CMD_W-1:0] cmd,
                                 logic [pfe_pkg::VAL_W-1:0] lit,
                                 logic [pfe_pkg::SEL_W-1:0] sel);
            logic [pfe_pkg::VAL_W-1:0] a, b;
            filter_result_t r;
            r.overflow_flag = 1'b0;
            r.zero_divide_flag = 1'b0;
            case (cmd)
                pfe_pkg::CMD_CLEAR: depth = 0;
                pfe_pkg::CMD_LOAD:
                    case (sel)
                        pfe_pkg::HDR_MAC_DST:  mac_dst = lit[47:0];
                        pfe_pkg::HDR_MAC_SRC:  mac_src = lit[47:0];
                        pfe_pkg::HDR_TYPE:     frame_type = lit[15:0];
                        pfe_pkg::HDR_PROTO:    proto_code = lit[7:0];
                        pfe_pkg::HDR_IP_SRC:   ip_src = lit[31:0];
                        pfe_pkg::HDR_IP_DST:   ip_dst = lit[31:0];
                        pfe_pkg::HDR_PORT_SRC: port_src = lit[15:0];
                        pfe_pkg::HDR_PORT_DST: port_dst = lit[15:0];
                        pfe_pkg::HDR_ICMP:     icmp_kind = lit[7:0];
                        default: ;
                    endcase
                pfe_pkg::CMD_LIT:   r.overflow_flag = push_entry(lit);
                pfe_pkg::CMD_FIELD: r.overflow_flag = push_entry(packet_field(sel));
                pfe_pkg::CMD_NOT:
                begin
                    a = pop_entry();
                    void'(push_entry(pfe_pkg::VAL_W'(a == '0)));
                end
                pfe_pkg::CMD_EQ, pfe_pkg::CMD_AND, pfe_pkg::CMD_OR, pfe_pkg::CMD_ADD,
                pfe_pkg::CMD_SUB, pfe_pkg::CMD_MUL, pfe_pkg::CMD_DIV, pfe_pkg::CMD_MOD:
                begin
                    b = pop_entry();
                    a = pop_entry();
                    case (cmd)
                        pfe_pkg::CMD_EQ:  a = pfe_pkg::VAL_W'(a == b);
                        pfe_pkg::CMD_AND: a = pfe_pkg::VAL_W'(a != '0 && b != '0);
                        pfe_pkg::CMD_OR:  a = pfe_pkg::VAL_W'(a != '0 || b != '0);
                        pfe_pkg::CMD_ADD: a = a + b;
                        pfe_pkg::CMD_SUB: a = a - b;
                        pfe_pkg::CMD_MUL: a = a * b;
                        default:
                        begin
                            if (b == '0)
                            begin
                                r.zero_divide_flag = 1'b1;
                                a = '0;
                            end
                            else
                                a = (cmd == pfe_pkg::CMD_DIV) ? a / b : a % b;
                        end
                    endcase
                    void'(push_entry(a));
                end
                default: ;
            endcase
            r.top_value = (depth != 0) ? shadow_stack[depth-1] : '0;
            r.stack_level = pfe_pkg::LEVEL_W'(depth);
            pending.push_back(r);
        endfunction

        // Compares one result with the oldest prediction.
        function void check_result(logic [pfe_pkg::OUT_W-1:0] data);
            filter_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[63:0] !== e.top_value)
            begin
                $display("%0t: top_value expected %h actual %h", $time, e.top_value,
                         data[63:0]);
                errors++;
            end
            if (data[68:64] !== e.stack_level)
            begin
                $display("%0t: stack_level expected %0d actual %0d", $time,
                         e.stack_level, data[68:64]);
                errors++;
            end
            if (data[69] !== e.overflow_flag)
            begin
                $display("%0t: overflow_flag expected %b actual %b", $time,
                         e.overflow_flag, data[69]);
                errors++;
            end
            if (data[70] !== e.zero_divide_flag)
            begin
                $display("%0t: zero_divide_flag expected %b actual %b", $time,
                         e.zero_divide_flag, data[70]);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [pfe_pkg::IN_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [pfe_pkg::OUT_W-1:0] m_tdata;

    filter_scoreboard board;
    bit               hold_off;
    bit               random_stalls;
    bit               drained;
    int               idle_cycles;
    int               sent_count;

    postfix_packet_filter_evaluator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one token and waits for it to be taken.
    task automatic send_token(logic [pfe_pkg::CMD_W-1:0] cmd,
                              logic [pfe_pkg::VAL_W-1:0] lit,
                              logic [pfe_pkg::SEL_W-1:0] sel);
        s_tvalid <= 1'b1;
        s_tdata  <= {sel, lit, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_token(cmd, lit, sel);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    function automatic logic [pfe_pkg::VAL_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return pfe_pkg::VAL_W'($urandom_range(0, 20));
            3:       return {32'h0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [pfe_pkg::SEL_W-1:0] random_sel();
        return pfe_pkg::SEL_W'($urandom_range(0, 15));
    endfunction

    // A well-formed filter: load a header, push fields and literals, combine.
    task automatic send_filter();
        int n;
        n = $urandom_range(1, 4);
        if ($urandom_range(0, 1))
            send_token(pfe_pkg::CMD_LOAD,
                       $urandom_range(0, 1) ? pfe_pkg::VAL_W'(pfe_pkg::TYPE_IPV4)
                                            : pfe_pkg::VAL_W'(pfe_pkg::TYPE_ARP),
                       pfe_pkg::HDR_TYPE);
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 3))
                0: send_token(pfe_pkg::CMD_LOAD, pfe_pkg::VAL_W'(pfe_pkg::PROTO_TCP),
                              pfe_pkg::HDR_PROTO);
                1: send_token(pfe_pkg::CMD_LOAD, pfe_pkg::VAL_W'(pfe_pkg::PROTO_UDP),
                              pfe_pkg::HDR_PROTO);
                2: send_token(pfe_pkg::CMD_LOAD, pfe_pkg::VAL_W'(pfe_pkg::PROTO_ICMP),
                              pfe_pkg::HDR_PROTO);
                default: send_token(pfe_pkg::CMD_LOAD, random_value(), pfe_pkg::HDR_PROTO);
            endcase
        end
        send_token(pfe_pkg::CMD_LOAD, random_value(), random_sel());
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 2))
                send_token(pfe_pkg::CMD_FIELD, random_value(), random_sel());
            else
                send_token(pfe_pkg::CMD_LIT, random_value(), random_sel());
        end
        for (int i = 0; i < n; i++)
        begin
            // Division is slow, so it is kept uncommon.
            if ($urandom_range(0, 9) == 0)
                send_token(pfe_pkg::CMD_W'($urandom_range(pfe_pkg::CMD_DIV,
                                                          pfe_pkg::CMD_MOD)),
                           random_value(), '0);
            else
                send_token(pfe_pkg::CMD_W'($urandom_range(pfe_pkg::CMD_EQ,
                                                          pfe_pkg::CMD_MUL)),
                           random_value(), '0);
        end
        if ($urandom_range(0, 3) == 0)
            send_token(pfe_pkg::CMD_CLEAR, random_value(), random_sel());
    endtask

    // Receiver: random stall pattern, plus a long hold-off when asked.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else if (random_stalls)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= 1'b1;
    end

    // Result checking and the no-progress watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("postfix_packet_filter_evaluator_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        hold_off      = 1'b0;
        random_stalls = 1'b0;
        drained       = 1'b0;
        idle_cycles   = 0;
        sent_count    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pops, extremes, every operation but field reads, zero divide.
        send_token(pfe_pkg::CMD_ADD, '0, '0);
        send_token(pfe_pkg::CMD_NOT, '0, '0);
        send_token(pfe_pkg::CMD_LIT, '1, 4'hF);
        send_token(pfe_pkg::CMD_LIT, '1, '0);
        send_token(pfe_pkg::CMD_MUL, '0, '0);
        send_token(pfe_pkg::CMD_LIT, '0, '0);
        send_token(pfe_pkg::CMD_DIV, '0, '0);
        send_token(pfe_pkg::CMD_LIT, '0, '0);
        send_token(pfe_pkg::CMD_MOD, '0, '0);
        send_token(pfe_pkg::CMD_LIT, 64'd100, '0);
        send_token(pfe_pkg::CMD_LIT, 64'd7, '0);
        send_token(pfe_pkg::CMD_MOD, '0, '0);
        send_token(pfe_pkg::CMD_LIT, 64'd5, '0);
        send_token(pfe_pkg::CMD_SUB, '0, '0);
        send_token(pfe_pkg::CMD_LIT, 64'd3, '0);
        send_token(pfe_pkg::CMD_DIV, '0, '0);
        send_token(pfe_pkg::CMD_OR, '0, '0);
        send_token(pfe_pkg::CMD_AND, '0, '0);
        send_token(pfe_pkg::CMD_EQ, '0, '0);
        send_token(CMD_RESERVED_LO, '1, 4'hF);
        send_token(CMD_RESERVED_HI, '0, '0);
        send_token(pfe_pkg::CMD_LOAD, '1, HDR_UNUSED);
        send_token(pfe_pkg::CMD_LOAD, '1, pfe_pkg::HDR_TYPE);
        send_token(pfe_pkg::CMD_CLEAR, '0, '0);

        // Fill past full while the receiver holds off.
        hold_off = 1'b1;
        fork
        begin
            repeat (200) @(negedge clk);
            hold_off = 1'b0;
        end
        for (int i = 0; i < pfe_pkg::STACK_DEPTH + 3; i++)
            send_token(pfe_pkg::CMD_FIELD, '0, i[3:0]);
        join
        send_token(pfe_pkg::CMD_CLEAR, '0, '0);

        // Random: mostly well-formed filters, some noise, bursty sender.
        random_stalls = 1'b1;
        while (sent_count < ITEM_COUNT)
        begin
            int burst;
            burst = $urandom_range(1, 6);
            for (int j = 0; j < burst; j++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_token(pfe_pkg::CMD_W'($urandom_range(0, 15)), random_value(),
                               random_sel());
                else
                    send_filter();
            end
            if ($urandom_range(0, 2) == 0)
                random_stalls = $urandom_range(0, 3) != 0;
            pause_sender($urandom_range(0, 6));
            // Once midway, drain everything before going on.
            if (!drained && sent_count >= ITEM_COUNT / 2)
            begin
                drained = 1'b1;
                s_tvalid <= 1'b0;
                do
                    @(negedge clk);
                while (board.pending.size() != 0);
            end
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (board.errors == 0)
            $display("postfix_packet_filter_evaluator_test: done, clean");
        else
            $display("postfix_packet_filter_evaluator_test: done, errors");
        $finish;
    end

endmodule
